@@ sv/scht_pkg.sv @@
// scht_pkg: shared types for the sorted hash counter table
// holds the sequencer state enum and the control struct sent to the cell row
// no dependencies
package scht_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int KEY_WIDTH_DEF   = 32;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int HASH_W  = 32;
  localparam int SLOT_W  = 6;
  localparam int COUNT_W = 32;

  // sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_UPD
  } state_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic cmp;   // latch compare flags against the incoming key
    logic inc;   // increment the matching entry
    logic ins;   // open a gap at the insertion point and load the key
  } cell_ctrl_t;

endpackage

@@ sv/scht_cell.sv @@
// scht_cell: one entry of the sorted table with its compare flags
// takes key and count from its lower neighbour when opening a gap
// depends on scht_pkg
module scht_cell #(
  parameter int KEY_WIDTH   = scht_pkg::KEY_WIDTH_DEF,
  parameter int COUNT_WIDTH = scht_pkg::COUNT_WIDTH_DEF,
  parameter int USED_W      = 7,
  parameter int INDEX       = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  scht_pkg::cell_ctrl_t   ctrl,
  input  logic [USED_W-1:0]      used,
  input  logic [KEY_WIDTH-1:0]   key_in,
  input  logic [KEY_WIDTH-1:0]   key_hold,
  input  logic [KEY_WIDTH-1:0]   prev_key,
  input  logic [COUNT_WIDTH-1:0] prev_count,
  input  logic                   prev_lt,
  output logic [KEY_WIDTH-1:0]   key,
  output logic [COUNT_WIDTH-1:0] count,
  output logic                   lt,
  output logic                   eq,
  output logic                   boundary,
  output logic [COUNT_WIDTH-1:0] count_inc
);

  logic occ;

  // entry holds data when its index is below the fill count
  assign occ = (used > USED_W'(INDEX));

  // first entry whose key is not below the search key
  assign boundary = !lt && prev_lt;

  // saturating increment
  assign count_inc = (count == {COUNT_WIDTH{1'b1}}) ? count : count + COUNT_WIDTH'(1);

  // compare flags
  always_ff @(posedge clk) begin
    if (rst) begin
      lt <= 1'b0;
      eq <= 1'b0;
    end else if (ctrl.cmp) begin
      lt <= occ && (key < key_in);
      eq <= occ && (key == key_in);
    end
  end

  // entry payload: increment, load or shift up
  always_ff @(posedge clk) begin
    if (ctrl.inc && eq) begin
      count <= count_inc;
    end else if (ctrl.ins && boundary) begin
      key   <= key_hold;
      count <= COUNT_WIDTH'(2);
    end else if (ctrl.ins && !prev_lt) begin
      key   <= prev_key;
      count <= prev_count;
    end
  end

endmodule

@@ sv/sorted_hash_counter_table.sv @@
// sorted_hash_counter_table: sorted key table with saturating occurrence counts
// row of scht_cell entries driven by a two-state sequencer; depends on scht_pkg
//
//   channel | direction | signals
//   in      | to block  | in_valid, in_stall, attr_hash
//   out     | from block| out_valid, out_stall, slot_index, new_count,
//           |           | was_inserted, table_full
//
// for each item, at acceptance all cells compare their key with the incoming one in
// parallel; in the following update state the row increments the hit or shifts
// up past the insertion point, and the result goes to the output register.
// the update cycle waits while a previous result is still stalled at the output.
// reset (synchronous) empties the table at once: only the fill count and compare flags are cleared.
module sorted_hash_counter_table #(
  parameter int TABLE_DEPTH = scht_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_WIDTH   = scht_pkg::KEY_WIDTH_DEF,
  parameter int COUNT_WIDTH = scht_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [scht_pkg::HASH_W-1:0]   attr_hash,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [scht_pkg::SLOT_W-1:0]   slot_index,
  output logic [scht_pkg::COUNT_W-1:0]  new_count,
  output logic                          was_inserted,
  output logic                          table_full
);

  localparam int USED_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W  = $clog2(TABLE_DEPTH);

  scht_pkg::state_t     state;
  scht_pkg::state_t     state_next;
  scht_pkg::cell_ctrl_t ctrl;

  logic [USED_W-1:0]      used;
  logic [KEY_WIDTH-1:0]   key_in;
  logic [KEY_WIDTH-1:0]   key_hold;
  logic                   accept;
  logic                   upd_en;
  logic                   hit;
  logic                   full;
  logic [IDX_W-1:0]       pos;
  logic [COUNT_WIDTH-1:0] hit_count;
  logic [scht_pkg::SLOT_W-1:0]  pos_slot;
  logic [scht_pkg::COUNT_W-1:0] hit_count_out;

  logic [KEY_WIDTH-1:0]   cell_key   [TABLE_DEPTH];
  logic [COUNT_WIDTH-1:0] cell_count [TABLE_DEPTH];
  logic [COUNT_WIDTH-1:0] cell_inc   [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] lt_vec;
  logic [TABLE_DEPTH-1:0] eq_vec;
  logic [TABLE_DEPTH-1:0] bnd_vec;

  // key taken from the hash, trimmed or widened to the table key width
  generate
    if (KEY_WIDTH <= scht_pkg::HASH_W) begin : g_key_trim
      assign key_in = attr_hash[KEY_WIDTH-1:0];
    end else begin : g_key_ext
      assign key_in = {{(KEY_WIDTH - scht_pkg::HASH_W){1'b0}}, attr_hash};
    end
  endgenerate

  assign accept = in_valid && !in_stall;
  assign in_stall = (state == scht_pkg::ST_UPD);
  assign upd_en = (state == scht_pkg::ST_UPD) && (!out_valid || !out_stall);
  assign hit  = |eq_vec;
  assign full = (used == USED_W'(TABLE_DEPTH));

  assign ctrl.cmp = accept;
  assign ctrl.inc = upd_en && hit;
  assign ctrl.ins = upd_en && !hit && !full;

  // row of cells, each fed from its lower neighbour
  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      logic [KEY_WIDTH-1:0]   p_key;
      logic [COUNT_WIDTH-1:0] p_count;
      logic                   p_lt;
      if (gi == 0) begin : g_first
        assign p_key   = '0;
        assign p_count = '0;
        assign p_lt    = 1'b1;
      end else begin : g_rest
        assign p_key   = cell_key[gi-1];
        assign p_count = cell_count[gi-1];
        assign p_lt    = lt_vec[gi-1];
      end
      scht_cell #(
        .KEY_WIDTH   (KEY_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH),
        .USED_W      (USED_W),
        .INDEX       (gi)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .used       (used),
        .key_in     (key_in),
        .key_hold   (key_hold),
        .prev_key   (p_key),
        .prev_count (p_count),
        .prev_lt    (p_lt),
        .key        (cell_key[gi]),
        .count      (cell_count[gi]),
        .lt         (lt_vec[gi]),
        .eq         (eq_vec[gi]),
        .boundary   (bnd_vec[gi]),
        .count_inc  (cell_inc[gi])
      );
    end
  endgenerate

  // gather position of the boundary cell and the incremented count of the hit
  always_comb begin
    pos       = '0;
    hit_count = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      pos       = pos | (bnd_vec[i] ? IDX_W'(i) : '0);
      hit_count = hit_count | (eq_vec[i] ? cell_inc[i] : '0);
    end
  end

  generate
    if (IDX_W >= scht_pkg::SLOT_W) begin : g_slot_trim
      assign pos_slot = pos[scht_pkg::SLOT_W-1:0];
    end else begin : g_slot_ext
      assign pos_slot = {{(scht_pkg::SLOT_W - IDX_W){1'b0}}, pos};
    end
    if (COUNT_WIDTH >= scht_pkg::COUNT_W) begin : g_cnt_trim
      assign hit_count_out = hit_count[scht_pkg::COUNT_W-1:0];
    end else begin : g_cnt_ext
      assign hit_count_out = {{(scht_pkg::COUNT_W - COUNT_WIDTH){1'b0}}, hit_count};
    end
  endgenerate

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scht_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      scht_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = scht_pkg::ST_UPD;
        end
      end
      scht_pkg::ST_UPD: begin
        if (upd_en) begin
          state_next = scht_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = scht_pkg::ST_IDLE;
      end
    endcase
  end

  // key held for the insert cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      key_hold <= key_in;
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (ctrl.ins) begin
      used <= used + USED_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_en) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en) begin
      if (hit) begin
        slot_index   <= pos_slot;
        new_count    <= hit_count_out;
        was_inserted <= 1'b0;
        table_full   <= 1'b0;
      end else if (full) begin
        slot_index   <= '0;
        new_count    <= '0;
        was_inserted <= 1'b0;
        table_full   <= 1'b1;
      end else begin
        slot_index   <= pos_slot;
        new_count    <= scht_pkg::COUNT_W'(2);
        was_inserted <= 1'b1;
        table_full   <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  // a key can match at most one entry of a sorted table
  a_one_hit: assert property (@(posedge clk) disable iff (rst) $onehot0(eq_vec))
    else $error("more than one entry matches the key");

  // the fill count never passes the table depth
  a_used_range: assert property (@(posedge clk) disable iff (rst)
    used <= USED_W'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  // a new result only appears after an update cycle
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == scht_pkg::ST_UPD)
    else $error("result without an update cycle");

  // an insert always grows the table by one entry
  a_ins_grow: assert property (@(posedge clk) disable iff (rst)
    ctrl.ins |=> used == $past(used) + USED_W'(1))
    else $error("insert did not grow the table");
`endif

endmodule

@@ tb/tb_top.sv @@
// tb_top: self-checking bench for sorted_hash_counter_table
// keeps its own sorted key/count table to predict every result; random gaps on both sides
// depends on scht_pkg and the sorted_hash_counter_table rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = scht_pkg::TABLE_DEPTH_DEF;
  localparam int RUN_LIMIT_NS = 5_000_000;
  localparam int TAIL_CYCLES  = 10;
  localparam int MAX_REPORTS  = 10;

  // one expected result
  typedef struct packed {
    logic [scht_pkg::SLOT_W-1:0]  slot;
    logic [scht_pkg::COUNT_W-1:0] count;
    logic                         inserted;
    logic                         full;
  } tally_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [scht_pkg::HASH_W-1:0]  attr_hash = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [scht_pkg::SLOT_W-1:0]  slot_index;
  logic [scht_pkg::COUNT_W-1:0] new_count;
  logic                         was_inserted;
  logic                         table_full;

  // predicted table contents, sorted by key
  logic [scht_pkg::HASH_W-1:0]  table_keys[DEPTH];
  logic [scht_pkg::COUNT_W-1:0] table_counts[DEPTH];
  int                           table_fill = 0;

  tally_t pending_tallies[$];
  int     fail_count = 0;
  int     stall_left = 0;
  bit     calm = 1'b0;

  sorted_hash_counter_table u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .attr_hash    (attr_hash),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .slot_index   (slot_index),
    .new_count    (new_count),
    .was_inserted (was_inserted),
    .table_full   (table_full)
  );

  always #5 clk = ~clk;

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // lower-bound search, then count the hit or open a gap and insert
  function automatic tally_t count_hash(logic [scht_pkg::HASH_W-1:0] key);
    tally_t t;
    int     pos;
    int     i;
    t = '0;
    pos = 0;
    while (pos < table_fill && table_keys[pos] < key) pos++;
    if (pos < table_fill && table_keys[pos] == key) begin
      if (table_counts[pos] != '1) table_counts[pos] = table_counts[pos] + 1'b1;
      t.slot  = scht_pkg::SLOT_W'(pos);
      t.count = table_counts[pos];
    end else if (table_fill >= DEPTH) begin
      t.full = 1'b1;
    end else begin
      for (i = table_fill; i > pos; i--) begin
        table_keys[i]   = table_keys[i - 1];
        table_counts[i] = table_counts[i - 1];
      end
      table_keys[pos]   = key;
      table_counts[pos] = scht_pkg::COUNT_W'(2);
      table_fill++;
      t.slot     = scht_pkg::SLOT_W'(pos);
      t.count    = table_counts[pos];
      t.inserted = 1'b1;
    end
    return t;
  endfunction

  function automatic bit is_stored(logic [scht_pkg::HASH_W-1:0] key);
    int i;
    for (i = 0; i < table_fill; i++) begin
      if (table_keys[i] == key) return 1'b1;
    end
    return 1'b0;
  endfunction

  // fresh key (sometimes next to a stored one) or a key already in the table
  function automatic logic [scht_pkg::HASH_W-1:0] pick_hash(int fresh_pct);
    logic [scht_pkg::HASH_W-1:0] near;
    if (table_fill == 0 || $urandom_range(0, 99) < fresh_pct) begin
      if (table_fill > 0 && $urandom_range(0, 3) == 0) begin
        near = table_keys[$urandom_range(0, table_fill - 1)];
        return $urandom_range(0, 1) ? near + 1'b1 : near - 1'b1;
      end
      return $urandom();
    end
    return table_keys[$urandom_range(0, table_fill - 1)];
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("mismatch: %s", msg);
  endfunction

  // present one item and hold it until accepted; valid stays high for a gapless next item
  task automatic send_hash(input logic [scht_pkg::HASH_W-1:0] h);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    attr_hash <= h;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_tallies.push_back(count_hash(h));
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_tallies.size() != 0) @(posedge clk);
  endtask

  // receiver stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (!calm) stall_left = pick_gap();
    end
  end

  // compare every accepted result with the oldest prediction
  always @(posedge clk) begin : check_result
    tally_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_tallies.size() == 0) begin
        note_failure($sformatf("unexpected result slot %0d count %0d ins %0b full %0b",
                               slot_index, new_count, was_inserted, table_full));
      end else begin
        want = pending_tallies.pop_front();
        if (slot_index !== want.slot)
          note_failure($sformatf("slot_index expected %0d got %0d", want.slot, slot_index));
        if (new_count !== want.count)
          note_failure($sformatf("new_count expected %0d got %0d", want.count, new_count));
        if (was_inserted !== want.inserted)
          note_failure($sformatf("was_inserted expected %0b got %0b",
                                 want.inserted, was_inserted));
        if (table_full !== want.full)
          note_failure($sformatf("table_full expected %0b got %0b", want.full, table_full));
      end
    end
  end

  // extremes, repeats and inserts at front, middle and end of an empty table
  task automatic test_first_keys();
    send_hash(32'h8000_0000);
    send_hash(32'h8000_0000);
    send_hash(32'h0000_0000);
    send_hash(32'hFFFF_FFFF);
    send_hash(32'h7FFF_FFFF);
    send_hash(32'h8000_0001);
    send_hash(32'hFFFF_FFFE);
    send_hash(32'h0000_0001);
    send_hash(32'hAAAA_AAAA);
    send_hash(32'h5555_5555);
    send_hash(32'h0000_0000);
    send_hash(32'hFFFF_FFFF);
    send_hash(32'h7FFF_FFFF);
    send_hash(32'hAAAA_AAAA);
  endtask

  // table grows under mostly repeated keys
  task automatic test_random_growth(int n);
    repeat (n) send_hash(pick_hash(18));
  endtask

  // sender holds off until every result is back, several times
  task automatic test_drain_pause();
    repeat (4) begin
      repeat ($urandom_range(5, 15)) send_hash(pick_hash(20));
      idle_input();
      wait_drained();
    end
  endtask

  // unique fresh keys until every entry is used
  task automatic test_fill_table();
    logic [scht_pkg::HASH_W-1:0] h;
    while (table_fill < DEPTH) begin
      do h = $urandom(); while (is_stored(h));
      send_hash(h);
    end
  endtask

  // full table: new keys rejected, known keys still counted, first and last slots
  task automatic test_full_table(int n);
    logic [scht_pkg::HASH_W-1:0] h;
    send_hash(table_keys[0]);
    send_hash(table_keys[DEPTH - 1]);
    do h = $urandom(); while (is_stored(h));
    send_hash(h);
    do h = table_keys[DEPTH / 2] + 1'b1; while (0);
    if (!is_stored(h)) send_hash(h);
    send_hash(table_keys[DEPTH / 2]);
    repeat (n) send_hash(pick_hash(40));
  endtask

  // no gaps and no stalls on either side
  task automatic test_back_to_back(int n);
    idle_input();
    wait_drained();
    calm = 1'b1;
    repeat (n) send_hash(pick_hash(30));
    idle_input();
    wait_drained();
    calm = 1'b0;
  endtask

  initial begin : run_tests
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_first_keys();
    test_random_growth(240);
    test_drain_pause();
    test_fill_table();
    test_full_table(380);
    test_back_to_back(120);
    test_random_growth(60);

    idle_input();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_tallies.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("tb: failure");
    $finish;
  end

endmodule
